// ===== rtl/base64_stream_decoder_unit_assert.svh =====
// Assertion helpers shared by the decoder RTL.
// B64D_ASSERT_SAME: consequent checked in the same cycle as the antecedent.
// B64D_ASSERT_NEXT: consequent checked in the cycle after the antecedent.
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define B64D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64d assertion failed");
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64d assertion failed");
`else
`define B64D_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/b64d_pkg.sv =====
`timescale 1ns / 1ps

package b64d_pkg;

    // Result queue sizing
    localparam int RES_DEPTH = 8;
    localparam int RES_PTR_W = 3;
    localparam int MAX_RES   = 4;

    // Result codes
    localparam logic KIND_DATA      = 1'b0;
    localparam logic KIND_END       = 1'b1;
    localparam logic REASON_NORMAL  = 1'b0;
    localparam logic REASON_INVALID = 1'b1;

    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        SC_SYMBOL,
        SC_SPACE,
        SC_PAD,
        SC_BAD
    } t_sym_class;

    typedef struct packed {
        t_sym_class cls;
        logic [5:0] value;
    } t_sym;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_total;
        logic        stop_reason;
        logic        is_last;
    } t_result;

    // Map one character to its 6-bit symbol or a class code
    function automatic t_sym classify(input logic [7:0] ch);
        t_sym s;
        s.cls   = SC_BAD;
        s.value = 6'd0;
        if (ch inside {["A":"Z"]}) begin
            s.cls   = SC_SYMBOL;
            s.value = 6'(ch - 8'd65);
        end else if (ch inside {["a":"z"]}) begin
            s.cls   = SC_SYMBOL;
            s.value = 6'(ch - 8'd71);
        end else if (ch inside {["0":"9"]}) begin
            s.cls   = SC_SYMBOL;
            s.value = 6'(ch + 8'd4);
        end else if (ch == "+") begin
            s.cls   = SC_SYMBOL;
            s.value = 6'd62;
        end else if (ch == "/") begin
            s.cls   = SC_SYMBOL;
            s.value = 6'd63;
        end else if (ch inside {8'h20, 8'h0D, 8'h0A, 8'h09}) begin
            s.cls = SC_SPACE;
        end else if (ch == "=") begin
            s.cls = SC_PAD;
        end
        return s;
    endfunction

endpackage

// ===== rtl/b64d_if.sv =====
`timescale 1ns / 1ps

// Text character channel
interface b64d_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       text_end;

    modport source (output valid, output text_char, output text_end, input ready);
    modport sink   (input valid, input text_char, input text_end, output ready);
endinterface

// Capacity register write channel
interface b64d_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_capacity;

    modport source (output valid, output out_capacity, input ready);
    modport sink   (input valid, input out_capacity, output ready);
endinterface

// Decoded result channel
interface b64d_result_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_total;
    logic        stop_reason;
    logic        is_last;

    modport source (output valid, output item_kind, output data_byte, output byte_total,
                    output stop_reason, output is_last, input ready);
    modport sink   (input valid, input item_kind, input data_byte, input byte_total,
                    input stop_reason, input is_last, output ready);
endinterface

// ===== rtl/b64d_result_fifo.sv =====
`timescale 1ns / 1ps
`include "base64_stream_decoder_unit_assert.svh"

module b64d_result_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [2:0]            i_push_cnt,
    input  b64d_pkg::t_result     i_push_data [b64d_pkg::MAX_RES],
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_room,
    output b64d_pkg::t_result     o_head
);
    import b64d_pkg::*;

    t_result                r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   r_wptr;
    logic [RES_PTR_W-1:0]   r_rptr;
    logic [RES_PTR_W:0]     r_count;

    // Up to MAX_RES entries written per cycle at consecutive slots
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RES; j++) begin
            if (3'(j) < i_push_cnt) begin
                r_mem[RES_PTR_W'(r_wptr + RES_PTR_W'(j))] <= i_push_data[j];
            end
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= RES_PTR_W'(r_wptr + RES_PTR_W'(i_push_cnt));
            if (i_pop) begin
                r_rptr <= RES_PTR_W'(r_rptr + 1'b1);
            end
            r_count <= (RES_PTR_W+1)'(r_count + (RES_PTR_W+1)'(i_push_cnt)
                                      - (RES_PTR_W+1)'(i_pop));
        end
    end

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= (RES_PTR_W+1)'(RES_DEPTH - MAX_RES));
    assign o_head  = r_mem[r_rptr];

    `B64D_ASSERT_SAME(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= (RES_PTR_W+1)'(RES_DEPTH))
    `B64D_ASSERT_SAME(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)
    `B64D_ASSERT_NEXT(a_count_track, i_clk, i_rst_n, !i_pop, r_count == (RES_PTR_W+1)'($past(r_count) + (RES_PTR_W+1)'($past(i_push_cnt))))

endmodule

// ===== rtl/base64_stream_decoder_unit.sv =====
`timescale 1ns / 1ps
`include "base64_stream_decoder_unit_assert.svh"
// Streaming base64 decoder.
// i_text carries one character per transfer, with text_end on the last one.
// i_cfg writes the per-text output byte limit (reset value 65535); write it
// only while the decoder is idle. Its ready is always high.
// o_result carries one result per transfer: data bytes, then one end marker
// per text with the byte count and stop reason; is_last flags the final
// result produced by a character.
// A character is registered on transfer, then decoded from that register
// into an 8-entry result queue once four slots are free; its first result
// is then presented on o_result from the queue registers.
// Throughput: one character per cycle and one result per cycle. A character
// can produce up to four results, so decode waits while fewer than four queue
// slots are free; when the receiver stalls the queue fills and i_text.ready
// drops until space returns.
// Reset clears the decoder state and the queue and restores the byte limit.
module base64_stream_decoder_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    b64d_text_if.sink      i_text,
    b64d_cfg_if.sink       i_cfg,
    b64d_result_if.source  o_result
);
    import b64d_pkg::*;

    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // Input register
    logic                  r_in_valid;
    logic [7:0]            r_in_char;
    logic                  r_in_end;

    // Decoder state
    logic [15:0]           r_out_capacity;
    logic [17:0]           r_hold;
    logic [1:0]            r_sym_count;
    logic [COUNT_BITS-1:0] r_bw;
    logic                  r_halted;
    logic                  r_pad_seen;

    logic [17:0]           n_hold;
    logic [1:0]            n_sym_count;
    logic [COUNT_BITS-1:0] n_bw;
    logic                  n_halted;
    logic                  n_pad_seen;

    logic                  w_room;
    logic                  w_fire;
    t_sym                  w_sym;
    logic [23:0]           w_group;
    logic [7:0]            w_cand [MAX_RES];
    logic [1:0]            w_n_cand;
    logic [CW:0]           w_lim;
    logic [CW:0]           w_bw_x;
    logic [2:0]            w_ok;
    logic [1:0]            w_emit;
    logic [CW-1:0]         w_total;
    logic [2:0]            w_n_res;
    t_result               w_res [MAX_RES];
    logic [2:0]            w_push_cnt;
    logic                  w_pop;
    t_result               w_head;
    logic                  w_q_valid;

    assign w_fire       = r_in_valid && w_room;
    assign i_text.ready = !r_in_valid || w_room;
    assign i_cfg.ready  = 1'b1;

    // Input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.valid && i_text.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_char <= i_text.text_char;
            r_in_end  <= i_text.text_end;
        end
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= CAP_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_out_capacity <= i_cfg.out_capacity;
        end
    end

    // Symbol gathering and candidate bytes
    always_comb begin
        w_sym       = classify(r_in_char);
        w_group     = {r_hold, w_sym.value};
        n_hold      = r_hold;
        n_sym_count = r_sym_count;
        n_halted    = r_halted;
        n_pad_seen  = r_pad_seen;
        w_n_cand    = 2'd0;
        for (int j = 0; j < MAX_RES; j++) begin
            w_cand[j] = 8'd0;
        end

        if (!r_halted && !r_pad_seen) begin
            case (w_sym.cls)
                SC_SYMBOL: begin
                    if (r_sym_count == 2'd3) begin
                        w_cand[0]   = w_group[23:16];
                        w_cand[1]   = w_group[15:8];
                        w_cand[2]   = w_group[7:0];
                        w_n_cand    = 2'd3;
                        n_hold      = '0;
                        n_sym_count = 2'd0;
                    end else begin
                        n_hold      = {r_hold[11:0], w_sym.value};
                        n_sym_count = 2'(r_sym_count + 1'b1);
                    end
                end
                SC_PAD: begin
                    n_pad_seen = 1'b1;
                end
                SC_BAD: begin
                    n_halted    = 1'b1;
                    n_hold      = '0;
                    n_sym_count = 2'd0;
                end
                default: begin
                end
            endcase
        end

        // Flush of a partial group at text end
        if (r_in_end && !n_halted) begin
            case (n_sym_count)
                2'd2: begin
                    w_cand[0] = n_hold[11:4];
                    w_n_cand  = 2'd1;
                end
                2'd3: begin
                    w_cand[0] = n_hold[17:10];
                    w_cand[1] = n_hold[9:2];
                    w_n_cand  = 2'd2;
                end
                default: begin
                end
            endcase
        end
    end

    // Capacity check: byte i goes out while the count stays below the limit
    always_comb begin
        w_bw_x = (CW+1)'(r_bw);
        if ((CW+1)'(r_out_capacity) < (CW+1)'({COUNT_BITS{1'b1}})) begin
            w_lim = (CW+1)'(r_out_capacity);
        end else begin
            w_lim = (CW+1)'({COUNT_BITS{1'b1}});
        end
        for (int i = 0; i < 3; i++) begin
            w_ok[i] = ((CW+1)'(w_bw_x + (CW+1)'(i)) < w_lim) && (2'(i) < w_n_cand);
        end
        w_emit  = 2'(w_ok[0]) + 2'(w_ok[1]) + 2'(w_ok[2]);
        w_total = CW'(w_bw_x + (CW+1)'(w_emit));
        w_n_res = 3'(w_emit) + 3'(r_in_end);
    end

    // Result batch: bytes first, then the end marker
    always_comb begin
        for (int j = 0; j < MAX_RES; j++) begin
            w_res[j] = '0;
            if (3'(j) < 3'(w_emit)) begin
                w_res[j].item_kind = KIND_DATA;
                w_res[j].data_byte = w_cand[j];
            end else begin
                w_res[j].item_kind   = KIND_END;
                w_res[j].byte_total  = w_total[15:0];
                w_res[j].stop_reason = n_halted ? REASON_INVALID : REASON_NORMAL;
            end
            w_res[j].is_last = (3'(j) == 3'(w_n_res - 3'd1));
        end
        w_push_cnt = w_fire ? w_n_res : 3'd0;
        n_bw       = COUNT_BITS'(w_total);
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= '0;
            r_sym_count <= 2'd0;
            r_bw        <= '0;
            r_halted    <= 1'b0;
            r_pad_seen  <= 1'b0;
        end else if (w_fire) begin
            if (r_in_end) begin
                r_hold      <= '0;
                r_sym_count <= 2'd0;
                r_bw        <= '0;
                r_halted    <= 1'b0;
                r_pad_seen  <= 1'b0;
            end else begin
                r_hold      <= n_hold;
                r_sym_count <= n_sym_count;
                r_bw        <= n_bw;
                r_halted    <= n_halted;
                r_pad_seen  <= n_pad_seen;
            end
        end
    end

    // Result queue
    assign w_pop = w_q_valid && o_result.ready;

    b64d_result_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (w_push_cnt),
        .i_push_data (w_res),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_room      (w_room),
        .o_head      (w_head)
    );

    assign o_result.valid       = w_q_valid;
    assign o_result.item_kind   = w_head.item_kind;
    assign o_result.data_byte   = w_head.data_byte;
    assign o_result.byte_total  = w_head.byte_total;
    assign o_result.stop_reason = w_head.stop_reason;
    assign o_result.is_last     = w_head.is_last;

    `B64D_ASSERT_SAME(a_marker_last, i_clk, i_rst_n, o_result.valid && (o_result.item_kind == KIND_END), o_result.is_last)
    `B64D_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, w_fire && r_in_end, (r_bw == '0) && !r_halted && !r_pad_seen && (r_sym_count == 2'd0))
    `B64D_ASSERT_SAME(a_halt_empty, i_clk, i_rst_n, r_halted, r_sym_count == 2'd0)

endmodule

// ===== sim/b64d_checker.sv =====
`timescale 1ns / 1ps

// Watches the text, capacity and result channels of the base64 decoder,
// predicts the results of every accepted character and compares them
// against the result transfers in order.
module b64d_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    b64d_text_if    i_text,
    b64d_cfg_if     i_cfg,
    b64d_result_if  i_result,
    output int      o_fail_count,
    output int      o_pending
);
    import b64d_pkg::*;

    // Character codes above the 6-bit symbol range
    localparam logic [6:0]  CODE_SKIP = 7'd64;
    localparam logic [6:0]  CODE_PAD  = 7'd65;
    localparam logic [6:0]  CODE_BAD  = 7'd66;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Predicted decoder state
    logic [15:0] capacity;
    logic [17:0] sym_acc;
    logic [1:0]  sym_cnt;
    logic [15:0] bytes_out;
    logic        stopped;
    logic        padded;

    t_result decoded_q[$];  // results still owed by the decoder
    t_result step_q[$];     // results of the character being decoded
    int      fail_cnt = 0;
    int      pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    // 6-bit value of a base64 symbol, or one of the codes above
    function automatic logic [6:0] char_code(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
        if (ch >= "a" && ch <= "z") return 7'(ch - "a" + 8'd26);
        if (ch >= "0" && ch <= "9") return 7'(ch - "0" + 8'd52);
        if (ch == "+") return 7'd62;
        if (ch == "/") return 7'd63;
        if (ch == 8'h20 || ch == 8'h0D || ch == 8'h0A || ch == 8'h09) return CODE_SKIP;
        if (ch == "=") return CODE_PAD;
        return CODE_BAD;
    endfunction

    // One data byte, dropped once the capacity is used up
    task automatic emit_data(input logic [7:0] b);
        t_result r;
        if (bytes_out < capacity && bytes_out < COUNT_MAX) begin
            bytes_out = bytes_out + 16'd1;
            r = '0;
            r.item_kind = KIND_DATA;
            r.data_byte = b;
            step_q.push_back(r);
        end
    endtask

    // Decode one character and queue the results it causes
    task automatic decode_char(input logic [7:0] ch, input logic last);
        logic [6:0]  code;
        logic [23:0] grp;
        t_result     r;
        step_q.delete();
        if (!stopped && !padded) begin
            code = char_code(ch);
            if (code < CODE_SKIP) begin
                if (sym_cnt == 2'd3) begin
                    grp = {sym_acc, code[5:0]};
                    emit_data(grp[23:16]);
                    emit_data(grp[15:8]);
                    emit_data(grp[7:0]);
                    sym_acc = '0;
                    sym_cnt = '0;
                end else begin
                    sym_acc = {sym_acc[11:0], code[5:0]};
                    sym_cnt = sym_cnt + 2'd1;
                end
            end else if (code == CODE_PAD) begin
                padded = 1'b1;
            end else if (code == CODE_BAD) begin
                stopped = 1'b1;
                sym_acc = '0;
                sym_cnt = '0;
            end
        end
        // Text end: flush the partial group, then the end marker
        if (last) begin
            if (!stopped) begin
                if (sym_cnt == 2'd2) begin
                    emit_data(sym_acc[11:4]);
                end else if (sym_cnt == 2'd3) begin
                    emit_data(sym_acc[17:10]);
                    emit_data(sym_acc[9:2]);
                end
            end
            r = '0;
            r.item_kind   = KIND_END;
            r.byte_total  = bytes_out;
            r.stop_reason = stopped ? REASON_INVALID : REASON_NORMAL;
            step_q.push_back(r);
            sym_acc   = '0;
            sym_cnt   = '0;
            bytes_out = '0;
            stopped   = 1'b0;
            padded    = 1'b0;
        end
        if (step_q.size() > 0) begin
            r = step_q.pop_back();
            r.is_last = 1'b1;
            step_q.push_back(r);
        end
        foreach (step_q[i]) decoded_q.push_back(step_q[i]);
    endtask

    // Result check first: a character accepted now has no result yet
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            capacity  = CAP_RESET;
            sym_acc   = '0;
            sym_cnt   = '0;
            bytes_out = '0;
            stopped   = 1'b0;
            padded    = 1'b0;
            decoded_q.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got.item_kind   = i_result.item_kind;
                got.data_byte   = i_result.data_byte;
                got.byte_total  = i_result.byte_total;
                got.stop_reason = i_result.stop_reason;
                got.is_last     = i_result.is_last;
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d byte=%02h total=%0d reason=%0d last=%0d",
                             $time, got.item_kind, got.data_byte, got.byte_total,
                             got.stop_reason, got.is_last);
                    fail_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (got.item_kind !== want.item_kind || got.data_byte !== want.data_byte ||
                        got.byte_total !== want.byte_total ||
                        got.stop_reason !== want.stop_reason || got.is_last !== want.is_last) begin
                        $display("%0t: result mismatch expected kind=%0d byte=%02h total=%0d reason=%0d last=%0d",
                                 $time, want.item_kind, want.data_byte, want.byte_total,
                                 want.stop_reason, want.is_last);
                        $display("%0t:                 actual   kind=%0d byte=%02h total=%0d reason=%0d last=%0d",
                                 $time, got.item_kind, got.data_byte, got.byte_total,
                                 got.stop_reason, got.is_last);
                        fail_cnt++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                capacity = i_cfg.out_capacity;
            end
            if (i_text.valid && i_text.ready) begin
                decode_char(i_text.text_char, i_text.text_end);
            end
        end
        pending_cnt = decoded_q.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import b64d_pkg::*;

    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_LIMIT = 4000;

    // Directed texts; bit 8 marks the last character of a text
    localparam logic [8:0] DIRECTED [26] = '{
        // full group, pad, then junk after the pad
        {1'b0, "T"}, {1'b0, "W"}, {1'b0, "F"}, {1'b0, "u"}, {1'b0, "S"},
        {1'b0, "Q"}, {1'b0, "="}, {1'b0, "="}, {1'b0, 8'h80}, {1'b1, 8'h0A},
        // white space between symbols, three-symbol tail
        {1'b0, "a"}, {1'b0, "/"}, {1'b0, "+"}, {1'b0, 8'h20}, {1'b0, 8'h09},
        {1'b0, 8'h0D}, {1'b0, "9"}, {1'b0, "0"}, {1'b0, "Z"}, {1'b1, "z"},
        // invalid character mid text
        {1'b0, "A"}, {1'b0, 8'hFF}, {1'b1, "B"},
        // empty text, lone symbol, invalid character as the end
        {1'b1, 8'h20}, {1'b1, "Q"}, {1'b1, 8'h00}
    };

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    bit   hold_req;
    int   chars_counted;
    int   fail_count;
    int   pending;

    b64d_text_if   text_bus ();
    b64d_cfg_if    cfg_bus ();
    b64d_result_if res_bus ();

    base64_stream_decoder_unit i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_text   (text_bus),
        .i_cfg    (cfg_bus),
        .o_result (res_bus)
    );

    b64d_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_text       (text_bus),
        .i_cfg        (cfg_bus),
        .i_result     (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result receiver: random stalls, or one long hold-off on request
    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            text_bus.valid <= 1'b0;
            @(negedge clk);
        end
        text_bus.valid     <= 1'b1;
        text_bus.text_char <= ch;
        text_bus.text_end  <= last;
        @(posedge clk);
        while (!text_bus.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        cfg_bus.valid        <= 1'b1;
        cfg_bus.out_capacity <= cap;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Wait until every predicted result has arrived, plus the decode latency
    task automatic wait_idle();
        int n;
        text_bus.valid <= 1'b0;
        n = 0;
        while (pending != 0 && n < DRAIN_LIMIT) begin
            @(negedge clk);
            n++;
        end
        repeat (6) @(negedge clk);
    endtask

    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        if (v < 6'd26) return 8'("A" + v);
        if (v < 6'd52) return 8'("a" + v - 8'd26);
        if (v < 6'd62) return 8'("0" + v - 8'd52);
        if (v == 6'd62) return "+";
        return "/";
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 3))
            0: return 8'h20;
            1: return 8'h0D;
            2: return 8'h0A;
            default: return 8'h09;
        endcase
    endfunction

    function automatic logic [7:0] bad_char();
        case ($urandom_range(0, 4))
            0: return 8'h80 | 8'($urandom_range(0, 127));
            1: return 8'($urandom_range(0, 8));
            2: return "-";
            3: return 8'($urandom_range(8'h3A, 8'h3C));
            default: return 8'h7F;
        endcase
    endfunction

    // One text: mostly symbol runs with some white space, pads and invalid
    // characters; now and then raw noise bytes
    task automatic send_random_text(input bit long_text);
        logic [7:0] chars[$];
        int         n_sym;
        int         bad_at;
        bit         dead;
        dead = 1'b0;
        if (!long_text && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
            chars_counted += chars.size();
        end else begin
            if (long_text) begin
                n_sym = $urandom_range(24, 40);
            end else if ($urandom_range(0, 9) == 0) begin
                n_sym = $urandom_range(10, 30);
            end else begin
                n_sym = $urandom_range(0, 9);
            end
            bad_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_sym) : -1;
            for (int i = 0; i < n_sym; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    chars.push_back(space_char());
                    if (!dead) chars_counted++;
                end
                if (i == bad_at) begin
                    chars.push_back(bad_char());
                    chars_counted++;
                    dead = 1'b1;
                end
                chars.push_back(b64_symbol(6'($urandom_range(0, 63))));
                if (!dead) chars_counted++;
            end
            // pad, then bytes the decoder ignores
            if (!dead && $urandom_range(0, 3) == 0) begin
                chars.push_back("=");
                chars_counted++;
                repeat ($urandom_range(0, 2)) chars.push_back(8'($urandom_range(0, 255)));
            end
            if (chars.size() == 0) begin
                chars.push_back(space_char());
                chars_counted++;
            end
        end
        foreach (chars[k]) send_char(chars[k], k == chars.size() - 1);
    endtask

    task automatic run_texts(input int target);
        chars_counted = 0;
        while (chars_counted < target) send_random_text(1'b0);
    endtask

    initial begin
        rst_n                = 1'b0;
        hold_req             = 1'b0;
        src_idle_pct         = 21;
        snk_idle_pct         = 58;
        text_bus.valid       = 1'b0;
        text_bus.text_char   = '0;
        text_bus.text_end    = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.out_capacity = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed texts at full capacity
        write_capacity(CAP_RESET);
        foreach (DIRECTED[i]) send_char(DIRECTED[i][7:0], DIRECTED[i][8]);

        // No bytes allowed: only end markers come out
        wait_idle();
        write_capacity(16'd0);
        repeat (3) send_random_text(1'b0);

        // Small capacity, sender idles less than receiver
        wait_idle();
        write_capacity(16'($urandom_range(1, 12)));
        run_texts(10);

        // Idling swapped
        wait_idle();
        src_idle_pct = 58;
        snk_idle_pct = 21;
        write_capacity(16'($urandom_range(2, 40)));
        run_texts(10);

        // No idling; a long receiver hold-off fills the result queue
        wait_idle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_capacity(CAP_RESET);
        hold_req = 1'b1;
        send_random_text(1'b1);
        run_texts(6);

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
